// ===== src/ttb_pkg.sv =====
// Shared types and constants for the triangle tangent basis block.
package ttb_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DeltaW = 33;
  localparam int unsigned ProdW  = 66;
  localparam int unsigned NumW   = 67;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] tex_u;
    logic signed [CoordW-1:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] tan_x;
    logic signed [CoordW-1:0] tan_y;
    logic signed [CoordW-1:0] tan_z;
    logic signed [CoordW-1:0] bitan_x;
    logic signed [CoordW-1:0] bitan_y;
    logic signed [CoordW-1:0] bitan_z;
    logic                     degenerate;
    logic                     last_of_triangle;
  } basis_t;

  // Deltas of one triangle, handed from front to back.
  typedef struct packed {
    logic signed [DeltaW-1:0] e1x;
    logic signed [DeltaW-1:0] e1y;
    logic signed [DeltaW-1:0] e1z;
    logic signed [DeltaW-1:0] e2x;
    logic signed [DeltaW-1:0] e2y;
    logic signed [DeltaW-1:0] e2z;
    logic signed [DeltaW-1:0] du1;
    logic signed [DeltaW-1:0] dv1;
    logic signed [DeltaW-1:0] du2;
    logic signed [DeltaW-1:0] dv2;
  } tri_t;

  typedef enum logic [2:0] {
    BkIdle, BkMul, BkDiv, BkEmit
  } bk_state_e;

endpackage

// ===== src/triangle_tangent_basis.sv =====
// Top level of the per-triangle tangent and bitangent unit.
//  channel | dir | handshake        | payload
//  vertex  | in  | vtx_valid_i/ready | ttb_pkg::vtx_t
//  basis   | out | res_valid_o/ready | ttb_pkg::basis_t
// One vertex is taken per cycle into the front unless its full output slot is stalled; every third forms a triangle.
// The back sweeps the products, then runs the serial divider per component
// (one quotient bit a cycle) unless the determinant is zero, then three result beats.
// Reset clears slot, queue and back state; held vertices are not cleared.
// Either side stalls on its own; the two-entry queue decouples them.
module triangle_tangent_basis #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vtx_valid_i,
  output logic            vtx_ready_o,
  input  ttb_pkg::vtx_t   vtx_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output ttb_pkg::basis_t res_o
);

  logic          f_valid, f_ready, b_valid, b_ready;
  ttb_pkg::tri_t f_tri, b_tri;

  ttb_front u_front (
    .clk_i, .rst_ni, .vtx_valid_i, .vtx_ready_o, .vtx_i,
    .tri_valid_o(f_valid), .tri_ready_i(f_ready), .tri_o(f_tri)
  );

  ttb_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_i(f_tri),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_o(b_tri)
  );

  ttb_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .tri_valid_i(b_valid), .tri_ready_o(b_ready), .tri_i(b_tri),
    .res_valid_o, .res_ready_i, .res_o
  );

endmodule

// ===== src/ttb_front.sv =====
// Front end: holds the first two vertices and forms triangle deltas.
module ttb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vtx_valid_i,
  output logic            vtx_ready_o,
  input  ttb_pkg::vtx_t   vtx_i,
  output logic            tri_valid_o,
  input  logic            tri_ready_i,
  output ttb_pkg::tri_t   tri_o
);

  logic [1:0]          slot_q, slot_d;
  ttb_pkg::vtx_t       v0_q, v1_q;
  logic                full_q, full_d;
  ttb_pkg::tri_t       tri_q, tri_d;
  logic                acc;

  function automatic logic signed [ttb_pkg::DeltaW-1:0] DeltaExt(
      logic signed [ttb_pkg::CoordW-1:0] a);
    DeltaExt = {a[ttb_pkg::CoordW-1], a};
  endfunction

  // Accept a vertex unless a finished triangle is stuck in the output slot.
  assign vtx_ready_o = !full_q || tri_ready_i;
  assign acc         = vtx_valid_i && vtx_ready_o;
  assign tri_valid_o = full_q;
  assign tri_o       = tri_q;

  always_comb begin
    tri_d.e1x = DeltaExt(v1_q.pos_x) - DeltaExt(v0_q.pos_x);
    tri_d.e1y = DeltaExt(v1_q.pos_y) - DeltaExt(v0_q.pos_y);
    tri_d.e1z = DeltaExt(v1_q.pos_z) - DeltaExt(v0_q.pos_z);
    tri_d.e2x = DeltaExt(vtx_i.pos_x) - DeltaExt(v0_q.pos_x);
    tri_d.e2y = DeltaExt(vtx_i.pos_y) - DeltaExt(v0_q.pos_y);
    tri_d.e2z = DeltaExt(vtx_i.pos_z) - DeltaExt(v0_q.pos_z);
    tri_d.du1 = DeltaExt(v1_q.tex_u) - DeltaExt(v0_q.tex_u);
    tri_d.dv1 = DeltaExt(v1_q.tex_v) - DeltaExt(v0_q.tex_v);
    tri_d.du2 = DeltaExt(vtx_i.tex_u) - DeltaExt(v0_q.tex_u);
    tri_d.dv2 = DeltaExt(vtx_i.tex_v) - DeltaExt(v0_q.tex_v);
  end

  // Advance the slot and the output flag.
  always_comb begin
    slot_d = slot_q;
    full_d = full_q && !tri_ready_i;
    if (acc) begin
      if (slot_q == 2'd2) begin
        slot_d = 2'd0;
        full_d = 1'b1;
      end else begin
        slot_d = slot_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
      full_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      full_q <= full_d;
    end
  end

  // Hold vertices and the delta beat.
  always_ff @(posedge clk_i) begin
    if (acc && slot_q == 2'd0) v0_q <= vtx_i;
    if (acc && slot_q == 2'd1) v1_q <= vtx_i;
    if (acc && slot_q == 2'd2) tri_q <= tri_d;
  end

endmodule

// ===== src/ttb_fifo.sv =====
// Short queue of triangle deltas between front and back.
module ttb_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ttb_pkg::tri_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ttb_pkg::tri_t out_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  ttb_pkg::tri_t    mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != Depth[AW:0];
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  function automatic logic [AW-1:0] Inc(logic [AW-1:0] p);
    Inc = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= Inc(wr_q);
      if (pop)  rd_q <= Inc(rd_q);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end

endmodule

// ===== src/ttb_back.sv =====
// Back end: products, serial division and emission of three result beats.
module ttb_back #(
  parameter int unsigned FracBits = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tri_valid_i,
  output logic            tri_ready_o,
  input  ttb_pkg::tri_t   tri_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output ttb_pkg::basis_t res_o
);

  localparam int unsigned NumW  = ttb_pkg::NumW;
  localparam int unsigned MagW  = NumW + FracBits;   // shifted magnitude
  localparam int unsigned QW    = MagW;
  localparam int unsigned CntW  = $clog2(MagW + 1);
  localparam int unsigned DW    = ttb_pkg::ProdW + 1;

  ttb_pkg::bk_state_e  st_q, st_d;
  ttb_pkg::tri_t       t_q;
  logic [3:0]          step_q;        // product step counter
  logic signed [NumW-1:0] acc_q;      // first product of a pair
  logic signed [NumW-1:0] num_q [6];
  logic signed [NumW-1:0] det_q;
  logic [DW-1:0]       dmag_q;
  logic [MagW-1:0]     n_q;
  logic [QW-1:0]       q_q;
  logic [DW:0]         r_q;
  logic [CntW-1:0]     bit_q;
  logic                neg_q;
  logic [2:0]          comp_q;
  logic [ttb_pkg::CoordW-1:0] vec_q [6];
  logic [1:0]          emit_q;
  logic                degen_q;

  // Multiplier operand selection, one 33x33 product a cycle.
  logic signed [ttb_pkg::DeltaW-1:0] ma, mb;
  logic signed [ttb_pkg::ProdW-1:0]  prod;
  logic signed [ttb_pkg::ProdW-1:0]  prod_q;
  always_comb begin
    unique case (step_q)
      4'd0:  begin ma = t_q.du1; mb = t_q.dv2; end
      4'd1:  begin ma = t_q.dv1; mb = t_q.du2; end
      4'd2:  begin ma = t_q.e1x; mb = t_q.dv2; end
      4'd3:  begin ma = t_q.e2x; mb = t_q.dv1; end
      4'd4:  begin ma = t_q.e1y; mb = t_q.dv2; end
      4'd5:  begin ma = t_q.e2y; mb = t_q.dv1; end
      4'd6:  begin ma = t_q.e1z; mb = t_q.dv2; end
      4'd7:  begin ma = t_q.e2z; mb = t_q.dv1; end
      4'd8:  begin ma = t_q.e2x; mb = t_q.du1; end
      4'd9:  begin ma = t_q.e1x; mb = t_q.du2; end
      4'd10: begin ma = t_q.e2y; mb = t_q.du1; end
      4'd11: begin ma = t_q.e1y; mb = t_q.du2; end
      4'd12: begin ma = t_q.e2z; mb = t_q.du1; end
      4'd13: begin ma = t_q.e1z; mb = t_q.du2; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;

  // Division step: restoring, one quotient bit a cycle.
  logic [DW:0]   r_sh;
  logic          ge;
  assign r_sh = {r_q[DW-1:0], n_q[MagW-1]};
  assign ge   = r_sh >= {1'b0, dmag_q};

  // Saturate the quotient by its sign.
  logic [ttb_pkg::CoordW-1:0] sat;
  always_comb begin
    if (!neg_q) begin
      sat = (q_q > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_q[31:0];
    end else begin
      sat = (q_q > QW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q_q[31:0]);
    end
  end

  assign tri_ready_o = (st_q == ttb_pkg::BkIdle);
  assign res_valid_o = (st_q == ttb_pkg::BkEmit);
  assign res_o.tan_x   = vec_q[0];
  assign res_o.tan_y   = vec_q[1];
  assign res_o.tan_z   = vec_q[2];
  assign res_o.bitan_x = vec_q[3];
  assign res_o.bitan_y = vec_q[4];
  assign res_o.bitan_z = vec_q[5];
  assign res_o.degenerate       = degen_q;
  assign res_o.last_of_triangle = emit_q == 2'd2;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ttb_pkg::BkIdle: if (tri_valid_i) st_d = ttb_pkg::BkMul;
      ttb_pkg::BkMul:  if (step_q == 4'd14) begin
        st_d = (det_q == '0) ? ttb_pkg::BkEmit : ttb_pkg::BkDiv;
      end
      ttb_pkg::BkDiv:  if (bit_q == '0 && comp_q == 3'd5) st_d = ttb_pkg::BkEmit;
      ttb_pkg::BkEmit: if (res_ready_i && emit_q == 2'd2) st_d = ttb_pkg::BkIdle;
      default:         st_d = ttb_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ttb_pkg::BkIdle;
      emit_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (st_q == ttb_pkg::BkEmit && res_ready_i) begin
        emit_q <= (emit_q == 2'd2) ? 2'd0 : emit_q + 2'd1;
      end
    end
  end

  // Datapath: product sweep, then six serial divisions unless the determinant is zero.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ttb_pkg::BkIdle: begin
        t_q    <= tri_i;
        step_q <= 4'd0;
      end
      ttb_pkg::BkMul: begin
        // Product of step k is registered; pair combines on even steps.
        prod_q <= prod;
        step_q <= step_q + 4'd1;
        if (step_q != 4'd0 && step_q[0]) acc_q <= NumW'(prod_q);
        if (step_q != 4'd0 && !step_q[0]) begin
          if (step_q == 4'd2) det_q <= acc_q - NumW'(prod_q);
          else num_q[3'((step_q >> 1) - 4'd2)] <= acc_q - NumW'(prod_q);
        end
        if (step_q == 4'd14) begin
          degen_q <= (det_q == '0);
          comp_q  <= 3'd0;
          dmag_q  <= det_q[NumW-1] ? DW'(-det_q) : DW'(det_q);
          r_q     <= '0;
          q_q     <= '0;
          bit_q   <= CntW'(MagW);
          for (int i = 0; i < 6; i++) vec_q[i] <= '0;
          neg_q   <= num_q[0][NumW-1] != det_q[NumW-1];
          n_q     <= {(num_q[0][NumW-1] ? NumW'(-num_q[0]) : num_q[0]),
                      FracBits'(0)};
        end
      end
      ttb_pkg::BkDiv: begin
        if (bit_q != '0) begin
          r_q   <= ge ? r_sh - {1'b0, dmag_q} : r_sh;
          q_q   <= {q_q[QW-2:0], ge};
          n_q   <= {n_q[MagW-2:0], 1'b0};
          bit_q <= bit_q - CntW'(1);
        end else begin
          vec_q[comp_q] <= sat;
          if (comp_q != 3'd5) begin
            comp_q <= comp_q + 3'd1;
            r_q    <= '0;
            q_q    <= '0;
            bit_q  <= CntW'(MagW);
            neg_q  <= num_q[comp_q + 3'd1][NumW-1] != det_q[NumW-1];
            n_q    <= {(num_q[comp_q + 3'd1][NumW-1] ? NumW'(-num_q[comp_q + 3'd1])
                                                       : num_q[comp_q + 3'd1]),
                       FracBits'(0)};
          end
        end
      end
      ttb_pkg::BkEmit: ;
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/tb_triangle_tangent_basis.sv =====
// Self-checking testbench for the per-triangle tangent and bitangent unit.
module tb_triangle_tangent_basis;

  localparam int unsigned FracBits = 16;
  localparam logic signed [127:0] QuotMax = 128'sh7fffffff;
  localparam logic signed [127:0] QuotMin = -QuotMax - 128'sd1;
  localparam int unsigned DrainCycles = 2000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            vtx_valid_i = 1'b0;
  logic            vtx_ready_o;
  ttb_pkg::vtx_t   vtx_i = '0;
  logic            res_valid_o;
  logic            res_ready_i = 1'b0;
  ttb_pkg::basis_t res_o;

  triangle_tangent_basis #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .vtx_valid_i, .vtx_ready_o, .vtx_i,
    .res_valid_o, .res_ready_i, .res_o
  );

  always #5 clk_i = ~clk_i;

  ttb_pkg::vtx_t   vertex_fifo[$];
  ttb_pkg::basis_t basis_expected[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     mismatches = 0;
  bit     vtx_taken = 1'b0;

  // Own copy of the triangle assembly state
  ttb_pkg::vtx_t held_vtx[2];
  bit [1:0]      slot_now = 2'd0;

  function automatic logic signed [31:0] scaled_div(logic signed [127:0] num,
                                                    logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FracBits) / den;
    if (q > QuotMax) return 32'h7fffffff;
    if (q < QuotMin) return 32'h80000000;
    return q[31:0];
  endfunction

  // Predict the three beats of a triangle closed by vertex c
  task automatic predict_triangle(ttb_pkg::vtx_t a, ttb_pkg::vtx_t b, ttb_pkg::vtx_t c);
    logic signed [127:0] p0[3], p1[3], p2[3], e1[3], e2[3];
    logic signed [127:0] du1, dv1, du2, dv2, det, tn, bn;
    ttb_pkg::basis_t r;
    p0[0] = a.pos_x; p0[1] = a.pos_y; p0[2] = a.pos_z;
    p1[0] = b.pos_x; p1[1] = b.pos_y; p1[2] = b.pos_z;
    p2[0] = c.pos_x; p2[1] = c.pos_y; p2[2] = c.pos_z;
    for (int j = 0; j < 3; j++) begin
      e1[j] = p1[j] - p0[j];
      e2[j] = p2[j] - p0[j];
    end
    du1 = 128'(b.tex_u) - 128'(a.tex_u);
    dv1 = 128'(b.tex_v) - 128'(a.tex_v);
    du2 = 128'(c.tex_u) - 128'(a.tex_u);
    dv2 = 128'(c.tex_v) - 128'(a.tex_v);
    det = du1 * dv2 - dv1 * du2;
    r = '0;
    r.degenerate = (det == 0);
    if (det != 0) begin
      tn = e1[0] * dv2 - e2[0] * dv1; r.tan_x = scaled_div(tn, det);
      tn = e1[1] * dv2 - e2[1] * dv1; r.tan_y = scaled_div(tn, det);
      tn = e1[2] * dv2 - e2[2] * dv1; r.tan_z = scaled_div(tn, det);
      bn = e2[0] * du1 - e1[0] * du2; r.bitan_x = scaled_div(bn, det);
      bn = e2[1] * du1 - e1[1] * du2; r.bitan_y = scaled_div(bn, det);
      bn = e2[2] * du1 - e1[2] * du2; r.bitan_z = scaled_div(bn, det);
    end
    for (int k = 0; k < 3; k++) begin
      r.last_of_triangle = (k == 2);
      basis_expected = {basis_expected, r};
    end
  endtask

  // Accept vertex beats into the predictor
  always @(posedge clk_i) begin
    vtx_taken <= rst_ni && vtx_valid_i && vtx_ready_o;
    if (rst_ni && vtx_valid_i && vtx_ready_o) begin
      if (slot_now < 2) begin
        held_vtx[slot_now[0]] = vtx_i;
        slot_now = slot_now + 2'd1;
      end else begin
        predict_triangle(held_vtx[0], held_vtx[1], vtx_i);
        slot_now = 2'd0;
      end
    end
  end

  // Check result beats against the oldest expectation
  always @(posedge clk_i) begin
    ttb_pkg::basis_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (basis_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", res_o);
      end else begin
        want = basis_expected.pop_front();
        if (res_o.tan_x !== want.tan_x || res_o.tan_y !== want.tan_y ||
            res_o.tan_z !== want.tan_z || res_o.bitan_x !== want.bitan_x ||
            res_o.bitan_y !== want.bitan_y || res_o.bitan_z !== want.bitan_z ||
            res_o.degenerate !== want.degenerate ||
            res_o.last_of_triangle !== want.last_of_triangle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, res_o);
        end
      end
    end
  end

  // Drive vertex beats and the result ready at the falling edge
  always @(negedge clk_i) begin
    logic nxt_valid;
    ttb_pkg::vtx_t nxt_vtx;
    nxt_valid = vtx_valid_i;
    nxt_vtx = vtx_i;
    if (vtx_taken) nxt_valid = 1'b0;
    if (rst_ni && !nxt_valid && vertex_fifo.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      nxt_vtx = vertex_fifo.pop_front();
      nxt_valid = 1'b1;
    end
    vtx_valid_i <= nxt_valid;
    vtx_i <= nxt_vtx;
    res_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic ttb_pkg::vtx_t mk_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           logic [31:0] u, logic [31:0] v);
    ttb_pkg::vtx_t t;
    t.pos_x = x; t.pos_y = y; t.pos_z = z; t.tex_u = u; t.tex_v = v;
    return t;
  endfunction

  // Append one vertex beat to the send queue
  task automatic queue_vertex(ttb_pkg::vtx_t v);
    vertex_fifo = {vertex_fifo, v};
  endtask

  // Queue one random triangle; some share a texture coordinate to go degenerate
  task automatic push_rand_triangle();
    int            mode;
    ttb_pkg::vtx_t t;
    bit            flat;
    mode = $urandom_range(9) < 4 ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
    flat = ($urandom_range(9) == 0);
    for (int k = 0; k < 3; k++) begin
      t = mk_vtx(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                 rand_coord(mode), rand_coord(mode));
      if (flat && k > 0) begin
        t.tex_u = vertex_fifo[$].tex_u;
        t.tex_v = vertex_fifo[$].tex_v;
      end
      queue_vertex(t);
    end
  endtask

  task automatic wait_fifo_sent();
    while (vertex_fifo.size() > 0 || vtx_valid_i) @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    wait_fifo_sent();
    while (basis_expected.size() > 0) @(posedge clk_i);
  endtask

  localparam logic [31:0] One = 32'h00010000;
  localparam logic [31:0] Max = 32'h7fffffff;
  localparam logic [31:0] Min = 32'h80000000;

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unit triangle
    queue_vertex(mk_vtx(0, 0, 0, 0, 0));
    queue_vertex(mk_vtx(One, 0, 0, One, 0));
    queue_vertex(mk_vtx(0, One, 0, 0, One));
    // Zero determinant: all texture coordinates equal
    queue_vertex(mk_vtx(One, 2 * One, 3 * One, One, One));
    queue_vertex(mk_vtx(Max, Min, 0, One, One));
    queue_vertex(mk_vtx(Min, Max, One, One, One));
    // Tiny determinant, huge edges: positive and negative saturation
    queue_vertex(mk_vtx(Min, Min, Max, 0, 0));
    queue_vertex(mk_vtx(Max, Max, Min, 1, 0));
    queue_vertex(mk_vtx(Min, Max, Min, 0, 1));
    // Extreme coordinates everywhere
    queue_vertex(mk_vtx(Max, Max, Max, Max, Min));
    queue_vertex(mk_vtx(Min, Min, Min, Min, Max));
    queue_vertex(mk_vtx(Max, Min, Max, Min, Min));
    queue_vertex(mk_vtx(Min, Max, Min, Max, Max));
    queue_vertex(mk_vtx(0, Max, Min, Max, 0));
    queue_vertex(mk_vtx(Max, 0, 0, 0, Max));
    // All-ones and alternating bit patterns
    queue_vertex(mk_vtx('1, 32'h55555555, 32'haaaaaaaa, '1, 32'h55555555));
    queue_vertex(mk_vtx(32'haaaaaaaa, '1, 32'h55555555, 32'haaaaaaaa, '1));
    queue_vertex(mk_vtx(32'h55555555, 32'haaaaaaaa, '1, 32'h55555555, 32'haaaaaaaa));
    wait_fifo_sent();
    // Hold off until the block has drained
    wait_results_done();

    // Random phases: none, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int n = 0; n < 14; n++) push_rand_triangle();
      wait_results_done();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && basis_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Give up after a generous bound
  initial begin
    #50000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== triangle_tangent_basis.f =====
src/ttb_pkg.sv
src/ttb_front.sv
src/ttb_fifo.sv
src/ttb_back.sv
src/triangle_tangent_basis.sv
tb/sv/tb_triangle_tangent_basis.sv
